/* sv/sxf_pkg.sv */
// Shared constants, codes and types of the sprite XOR frame buffer.
`default_nettype none

package sxf_pkg;

  // Frame geometry; both must be powers of two.
  localparam int unsigned FrameWidth  = 64;
  localparam int unsigned FrameHeight = 32;
  localparam int unsigned ColW        = $clog2(FrameWidth);
  localparam int unsigned RowW        = $clog2(FrameHeight);

  // Field widths of one input word.
  localparam int unsigned XW          = 6;
  localparam int unsigned YW          = 5;
  localparam int unsigned RowIdxW     = 4;
  localparam int unsigned SpriteBits  = 8;
  localparam int unsigned PixRowW     = 64;

  typedef enum logic [1:0] {
    FuncClear = 2'd0,
    FuncDraw  = 2'd1,
    FuncRead  = 2'd2,
    FuncAck   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StOut  = 3'b100
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the input word and start the row read
    logic exec;  // apply the word, update flags and the output register
  } sxf_cmd_t;

endpackage : sxf_pkg

`default_nettype wire

/* sv/sxf_if.sv */
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface sxf_in_if;
  import sxf_pkg::*;

  logic                 valid;
  logic                 ready;
  func_e                func;
  logic [XW-1:0]        x;
  logic [YW-1:0]        y;
  logic [RowIdxW-1:0]   row_index;
  logic [SpriteBits-1:0] sprite_bits;
  logic                 last_row;

  modport source (
    output valid, func, x, y, row_index, sprite_bits, last_row,
    input  ready
  );
  modport sink (
    input  valid, func, x, y, row_index, sprite_bits, last_row,
    output ready
  );
endinterface : sxf_in_if

interface sxf_out_if;
  import sxf_pkg::*;

  logic               valid;
  logic               ready;
  logic               collision;
  logic [PixRowW-1:0] pixel_row;
  logic               redraw_pending;

  modport source (
    output valid, collision, pixel_row, redraw_pending,
    input  ready
  );
  modport sink (
    input  valid, collision, pixel_row, redraw_pending,
    output ready
  );
endinterface : sxf_out_if

`default_nettype wire

/* sv/sxf_ctrl.sv */
// Controller state machine: sequences one word through load, execute and output.
`default_nettype none

module sxf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output sxf_pkg::sxf_cmd_t   cmd_o
);
  import sxf_pkg::*;

  ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StExec;
      StExec: state_d = StOut;
      StOut:  if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign cmd_o.load  = (state_q == StIdle) && in_valid_i;
  assign cmd_o.exec  = (state_q == StExec);

endmodule : sxf_ctrl

`default_nettype wire

/* sv/sxf_dp.sv */
// Datapath: frame row memory, row valid bits, XOR/collision logic and result register.
`default_nettype none

module sxf_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sxf_pkg::sxf_cmd_t           cmd_i,
  input  wire sxf_pkg::func_e              func_i,
  input  wire logic [sxf_pkg::XW-1:0]      x_i,
  input  wire logic [sxf_pkg::YW-1:0]      y_i,
  input  wire logic [sxf_pkg::RowIdxW-1:0] row_index_i,
  input  wire logic [sxf_pkg::SpriteBits-1:0] sprite_bits_i,
  output logic                             collision_o,
  output logic [sxf_pkg::PixRowW-1:0]      pixel_row_o,
  output logic                             redraw_pending_o
);
  import sxf_pkg::*;

  localparam int unsigned SumW = ((YW > RowIdxW) ? YW : RowIdxW) + 1;
  localparam int unsigned XSumW = ((XW > ColW) ? XW : ColW) + 1;

  // Frame row memory; an invalid row reads as blank.
  logic [FrameWidth-1:0]  mem [FrameHeight];
  logic [FrameHeight-1:0] row_valid_q, row_valid_d;
  logic [FrameWidth-1:0]  rd_data_q;
  logic                   rd_valid_q;

  // Captured word
  func_e                  func_q;
  logic [XW-1:0]          x_q;
  logic [SpriteBits-1:0]  bits_q;
  logic                   ri_zero_q;
  logic [RowW-1:0]        row_q;

  logic                   coll_q, coll_d;
  logic                   redraw_q, redraw_d;
  logic [PixRowW-1:0]     pix_q, pix_d;

  logic [SumW-1:0]        row_sum;
  logic [RowW-1:0]        addr;
  logic [FrameWidth-1:0]  line;
  logic [FrameWidth-1:0]  mask;
  logic [FrameWidth-1:0]  new_line;
  logic                   hit;
  logic                   mem_we;

  // Target row: wraps modulo the frame height.
  assign row_sum = SumW'(y_i) + SumW'(row_index_i);
  always_comb begin
    if (func_i == FuncDraw) begin
      addr = RowW'(row_sum % FrameHeight);
    end else begin
      addr = RowW'(y_i % FrameHeight);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_data_q <= mem[addr];
      func_q    <= func_i;
      x_q       <= x_i;
      bits_q    <= sprite_bits_i;
      ri_zero_q <= (row_index_i == '0);
      row_q     <= addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      rd_valid_q <= row_valid_q[addr];
    end
  end

  assign line = rd_valid_q ? rd_data_q : '0;

  // Sprite byte to column mask, bit 7 leftmost, columns wrap.
  always_comb begin
    logic [XSumW-1:0] col;
    mask = '0;
    for (int c = 0; c < SpriteBits; c++) begin
      col = XSumW'(x_q) + XSumW'(c);
      if (bits_q[SpriteBits-1-c]) begin
        mask[ColW'(col % FrameWidth)] = 1'b1;
      end
    end
  end

  assign hit      = |(line & mask);
  assign new_line = line ^ mask;

  always_comb begin
    row_valid_d = row_valid_q;
    coll_d      = coll_q;
    redraw_d    = redraw_q;
    pix_d       = '0;
    mem_we      = 1'b0;
    case (func_q)
      FuncClear: begin
        row_valid_d = '0;
        redraw_d    = 1'b1;
      end
      FuncDraw: begin
        mem_we             = 1'b1;
        row_valid_d[row_q] = 1'b1;
        coll_d             = (coll_q & ~ri_zero_q) | hit;
        redraw_d           = 1'b1;
      end
      FuncRead: begin
        pix_d = PixRowW'(line);
      end
      FuncAck: begin
        redraw_d = 1'b0;
      end
      default: begin
        redraw_d = redraw_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) begin
      mem[row_q] <= new_line;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      coll_q      <= 1'b0;
      redraw_q    <= 1'b0;
    end else if (cmd_i.exec) begin
      row_valid_q <= row_valid_d;
      coll_q      <= coll_d;
      redraw_q    <= redraw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      pix_q <= pix_d;
    end
  end

  assign collision_o      = coll_q;
  assign redraw_pending_o = redraw_q;
  assign pixel_row_o      = pix_q;

endmodule : sxf_dp

`default_nettype wire

/* sv/sprite_xor_framebuffer.sv */
// Top level of the sprite XOR frame buffer: controller plus datapath.
`default_nettype none

// Channel   Dir  Payload                                              Meaning
// item_i    in   func, x, y, row_index, sprite_bits, last_row         one word per request
// result_o  out  collision, pixel_row, redraw_pending                 one word per request
//
// Each word goes through load (row read issued), execute (read data
// back, XOR and write back), then the result waits in the output register.
// The next word is taken the cycle after the result has been handed off; the
// registered row read ahead of the write back, and the controller holding off
// new words while a result waits, keep a single word in the block at a time.
// Reset clears the row valid bits, so the frame reads blank at once; there
// is no clearing sweep. A stalled result simply holds the block in output.
// A clear word drops all row valid bits at once.

module sprite_xor_framebuffer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sxf_in_if.sink     item_i,
  sxf_out_if.source  result_o
);
  import sxf_pkg::*;

  sxf_cmd_t cmd;

  // Controller: owns the handshakes and steps the datapath.
  sxf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  // Datapath: frame memory, flags and result register. last_row carries
  // no behavior and is not used.
  sxf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .func_i           (item_i.func),
    .x_i              (item_i.x),
    .y_i              (item_i.y),
    .row_index_i      (item_i.row_index),
    .sprite_bits_i    (item_i.sprite_bits),
    .collision_o      (result_o.collision),
    .pixel_row_o      (result_o.pixel_row),
    .redraw_pending_o (result_o.redraw_pending)
  );

endmodule : sprite_xor_framebuffer

`default_nettype wire
